FILE: sv/rlne_pkg.sv
package rlne_pkg;

  localparam int SAMPLE_WIDTH          = 16;
  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int TIME_WIDTH            = 64;
  localparam int TAU_WIDTH             = 32;
  localparam int AMP_WIDTH             = 15;
  localparam int SEED_WIDTH            = 31;
  localparam int CFG_DATA_WIDTH        = 32;
  localparam int CFG_INDEX_WIDTH       = 2;
  localparam int MUL_WIDTH             = 32;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAU  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_AMP  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEED = 2'd2;

  // noise generator
  localparam logic [SEED_WIDTH-1:0] SEED_RESET      = 31'd1;
  localparam logic [MUL_WIDTH-1:0]  LCG_MUL         = 32'd1103515245;
  localparam logic [SEED_WIDTH-1:0] LCG_ADD         = 31'd12345;
  localparam int                    NOISE_DROP_BITS = 8;
  localparam int                    NOISE_U_WIDTH   = SEED_WIDTH - NOISE_DROP_BITS;
  localparam int                    NOISE_HALF_BITS = NOISE_U_WIDTH - 1;
  localparam logic [NOISE_U_WIDTH-1:0] NOISE_CENTRE = 23'h400000;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] target_sample;
    logic [TIME_WIDTH-1:0]          time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] node_sample;
    logic                           restarted;
  } out_item_t;

endpackage

FILE: sv/rc_lowpass_noise_emulator.sv
// RC low-pass node emulator with uniform noise.
// in channel: in_valid / in_stall carry a target sample and a microsecond
// timestamp; out channel: out_valid / out_stall carry the node sample and a
// restart flag. One result per item, in order.
// Items are handled one at a time; in_stall is high while an item is in work.
// A restart item (first after reset, or time running backward) goes from the
// decide step straight to the rounding step. Other items pass through the
// serial divider for alpha (one quotient bit per cycle) and the one shared
// multiplier (two passes for the node step and, when the amplitude is not
// zero, one for the noise generator and one for the noise scale). Items with
// zero tau, elapsed time at or above tau, or equal timestamps skip the divider
// and the node step passes. The result sits in an output register, so a
// new item is taken while out_stall holds the last result; a finished item
// waits in its last step only if the output register is still full.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and belong to idle periods; writing the seed reloads the noise generator.
// Reset (rst, synchronous) clears the node, the time base and the registers,
// and loads the noise generator with 1.
module rc_lowpass_noise_emulator import rlne_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_item_t                  out_data,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int NW   = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int TW   = NW + 2;
  localparam int PW   = 2 * MUL_WIDTH;
  localparam int NSHL = (FRACTION_BITS >= NOISE_HALF_BITS) ? FRACTION_BITS - NOISE_HALF_BITS : 0;
  localparam int NSHR = (FRACTION_BITS >= NOISE_HALF_BITS) ? 0 : NOISE_HALF_BITS - FRACTION_BITS;

  localparam logic signed [TW-1:0] HALF_T =
    $signed({{(TW-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}});
  localparam logic signed [TW-1:0] SMAX_T =
    $signed({{(TW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [TW-1:0] SMIN_T =
    $signed({{(TW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}});

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CHECK, S_DIV, S_MUL_HI, S_MUL_LO, S_PROD, S_APPLY,
    S_NOISE, S_LCG_WAIT, S_DEV, S_NMUL, S_NWAIT, S_ROUND
  } state_t;

  state_t state;

  // configuration and long-lived state
  logic [TAU_WIDTH-1:0]           tau;
  logic [AMP_WIDTH-1:0]           amp;
  logic [SEED_WIDTH-1:0]          noise_state;
  logic signed [NW-1:0]           node;
  logic [TIME_WIDTH-1:0]          last_time;
  logic                           started;

  // per-item working registers
  logic signed [SAMPLE_WIDTH-1:0] target;
  logic [TIME_WIDTH-1:0]          now;
  logic [TIME_WIDTH-1:0]          dt;
  logic signed [NW:0]             diff;
  logic [NW-1:0]                  mag_m;
  logic                           neg;
  logic [NW-1:0]                  acc;
  logic [NW-1:0]                  prod;
  logic [NOISE_U_WIDTH-1:0]       dev;
  logic                           nneg;
  logic signed [TW-1:0]           total;
  logic                           restart_flag;

  // shared multiplier and divider
  logic [MUL_WIDTH-1:0]           mul_a;
  logic [MUL_WIDTH-1:0]           mul_b;
  logic [PW-1:0]                  mul_p;
  logic                           div_start;
  logic                           div_done;
  logic [FRACTION_BITS-1:0]       alpha;

  logic signed [NW-1:0]           target_q;
  logic                           restart;
  logic signed [NW:0]             diff_neg;
  logic [NOISE_U_WIDTH-1:0]       u;
  logic [PW-1:0]                  noise_shifted;
  logic signed [TW-1:0]           node_ext;
  logic signed [TW-1:0]           mag_s;
  logic signed [TW-1:0]           rnd;
  logic signed [TW-1:0]           val;
  logic signed [TW-1:0]           sat;

  assign target_q      = $signed({target, {FRACTION_BITS{1'b0}}});
  assign restart       = !started || (now < last_time);
  assign diff_neg      = -diff;
  assign u             = noise_state[SEED_WIDTH-1:NOISE_DROP_BITS];
  assign noise_shifted = (mul_p >> NSHR) << NSHL;
  assign node_ext      = TW'(node);
  assign mag_s         = $signed(noise_shifted[TW-1:0]);
  assign rnd           = total + HALF_T;
  assign val           = rnd >>> FRACTION_BITS;

  always_comb begin
    if (val > SMAX_T) begin
      sat = SMAX_T;
    end else if (val < SMIN_T) begin
      sat = SMIN_T;
    end else begin
      sat = val;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign div_start = (state == S_CHECK) && (tau != '0) && (dt < TIME_WIDTH'(tau)) &&
                     (dt != '0);

  always_comb begin
    case (state)
      S_MUL_HI: begin
        mul_a = MUL_WIDTH'(mag_m[NW-1:FRACTION_BITS]);
        mul_b = MUL_WIDTH'(alpha);
      end
      S_MUL_LO: begin
        mul_a = MUL_WIDTH'(mag_m[FRACTION_BITS-1:0]);
        mul_b = MUL_WIDTH'(alpha);
      end
      S_NOISE: begin
        mul_a = MUL_WIDTH'(noise_state);
        mul_b = LCG_MUL;
      end
      S_NMUL: begin
        mul_a = MUL_WIDTH'(dev);
        mul_b = MUL_WIDTH'(amp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rlne_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rlne_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dt[TAU_WIDTH-1:0]),
    .divisor  (tau),
    .done     (div_done),
    .quotient (alpha)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tau         <= '0;
      amp         <= '0;
      noise_state <= SEED_RESET;
      node        <= '0;
      last_time   <= '0;
      started     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // the rounding step refills the output register itself
      if (out_valid && !out_stall && state != S_ROUND) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_TAU:  tau <= cfg_data[TAU_WIDTH-1:0];
          REG_AMP:  amp <= cfg_data[AMP_WIDTH-1:0];
          REG_SEED: noise_state <= cfg_data[SEED_WIDTH-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            target <= in_data.target_sample;
            now    <= in_data.time_us;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          restart_flag <= restart;
          last_time    <= now;
          started      <= 1'b1;
          dt           <= now - last_time;
          if (restart) begin
            node  <= target_q;
            total <= TW'(target_q);
            state <= S_ROUND;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          diff <= (NW+1)'(target_q) - (NW+1)'(node);
          if (tau == '0 || dt >= TIME_WIDTH'(tau)) begin
            node  <= target_q;
            state <= S_NOISE;
          end else if (dt == '0) begin
            state <= S_NOISE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          neg   <= diff[NW];
          mag_m <= diff[NW] ? diff_neg[NW-1:0] : diff[NW-1:0];
          if (div_done) begin
            state <= S_MUL_HI;
          end
        end
        S_MUL_HI: begin
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          acc   <= mul_p[NW-1:0];
          state <= S_PROD;
        end
        S_PROD: begin
          // low partial product contributes only its whole part
          prod  <= acc + NW'(mul_p >> FRACTION_BITS);
          state <= S_APPLY;
        end
        S_APPLY: begin
          node  <= $signed(neg ? $unsigned(node) - prod : $unsigned(node) + prod);
          state <= S_NOISE;
        end
        S_NOISE: begin
          if (amp == '0) begin
            total <= node_ext;
            state <= S_ROUND;
          end else begin
            state <= S_LCG_WAIT;
          end
        end
        S_LCG_WAIT: begin
          noise_state <= mul_p[SEED_WIDTH-1:0] + LCG_ADD;
          state       <= S_DEV;
        end
        S_DEV: begin
          nneg  <= u < NOISE_CENTRE;
          dev   <= (u < NOISE_CENTRE) ? NOISE_CENTRE - u : u - NOISE_CENTRE;
          state <= S_NMUL;
        end
        S_NMUL: begin
          state <= S_NWAIT;
        end
        S_NWAIT: begin
          total <= nneg ? node_ext - mag_s : node_ext + mag_s;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            out_data.node_sample <= sat[SAMPLE_WIDTH-1:0];
            out_data.restarted   <= restart_flag;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ap_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  ap_alpha_below_one: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dt < TIME_WIDTH'(tau))
    else $error("divide started with elapsed time not below tau");

  ap_noise_state_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(noise_state) |-> $past(rst) || $past(state == S_LCG_WAIT) ||
      $past(cfg_write && cfg_index == REG_SEED))
    else $error("noise generator moved without a step or a seed write");

  ap_result_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_ROUND))
    else $error("result appeared outside the rounding step");

endmodule

FILE: sv/rlne_mul.sv
module rlne_mul import rlne_pkg::*; (
  input  logic                     clk,
  input  logic [MUL_WIDTH-1:0]     a,
  input  logic [MUL_WIDTH-1:0]     b,
  output logic [2*MUL_WIDTH-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= {{MUL_WIDTH{1'b0}}, a} * {{MUL_WIDTH{1'b0}}, b};
  end

endmodule

FILE: sv/rlne_div.sv
module rlne_div import rlne_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [TAU_WIDTH-1:0]     dividend,
  input  logic [TAU_WIDTH-1:0]     divisor,
  output logic                     done,
  output logic [FRACTION_BITS-1:0] quotient
);

  localparam int CW = $clog2(FRACTION_BITS + 1);

  logic [TAU_WIDTH-1:0] rem;
  logic [TAU_WIDTH-1:0] dsr;
  logic [TAU_WIDTH:0]   rem_dbl;
  logic [TAU_WIDTH:0]   rem_sub;
  logic                 fits;
  logic [CW-1:0]        count;
  logic                 busy;

  // remainder stays below the divisor, so doubling never loses a bit
  assign rem_dbl = {rem, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, dsr};
  assign fits    = rem_dbl >= {1'b0, dsr};
  assign done    = busy && (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(FRACTION_BITS);
      rem   <= dividend;
      dsr   <= divisor;
    end else if (busy) begin
      if (count != '0) begin
        rem      <= fits ? rem_sub[TAU_WIDTH-1:0] : rem_dbl[TAU_WIDTH-1:0];
        quotient <= {quotient[FRACTION_BITS-2:0], fits};
        count    <= count - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: sim/tb_rc_lowpass_noise_emulator.sv
module tb_rc_lowpass_noise_emulator;
  timeunit 1ns;
  timeprecision 1ps;

  import rlne_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEFAULT;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam int MAX_GAP = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 113;

  class rc_node_checker;
    logic [TAU_WIDTH-1:0] tau;
    logic [AMP_WIDTH-1:0] amp;
    logic [SEED_WIDTH-1:0] lcg_state;
    longint node_q16;
    logic [TIME_WIDTH-1:0] prev_time;
    bit primed;
    out_item_t expected_samples[$];
    int errors;
    int seen;
    int restarts;
    int clamped;

    function new();
      tau = '0;
      amp = '0;
      lcg_state = SEED_RESET;
      node_q16 = 0;
      prev_time = '0;
      primed = 1'b0;
      errors = 0;
      seen = 0;
      restarts = 0;
      clamped = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
      case (idx)
        REG_TAU: tau = val[TAU_WIDTH-1:0];
        REG_AMP: amp = val[AMP_WIDTH-1:0];
        REG_SEED: lcg_state = val[SEED_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void note_item(in_item_t it);
      longint target_q;
      longint total;
      longint rounded;
      longint diff;
      logic [63:0] dt;
      logic [63:0] alpha;
      logic [63:0] diff_mag;
      logic [63:0] prod;
      logic [63:0] lcg_next;
      logic [63:0] u;
      logic [63:0] mag;
      bit neg;
      out_item_t res;
      seen++;
      target_q = longint'($signed(it.target_sample)) <<< FRAC;
      if (!primed || it.time_us < prev_time) begin
        node_q16 = target_q;
        prev_time = it.time_us;
        primed = 1'b1;
        res.node_sample = it.target_sample;
        res.restarted = 1'b1;
        restarts++;
        expected_samples.push_back(res);
        return;
      end
      if (tau == '0) begin
        node_q16 = target_q;
      end else begin
        dt = it.time_us - prev_time;
        if (dt >= 64'(tau)) begin
          node_q16 = target_q;
        end else if (dt != 64'd0) begin
          alpha = (dt << FRAC) / 64'(tau);
          diff = target_q - node_q16;
          neg = diff < 0;
          diff_mag = neg ? -diff : diff;
          // split product keeps the low fraction bits truncated like the block
          prod = (diff_mag >> FRAC) * alpha
            + (((diff_mag & ((64'd1 << FRAC) - 64'd1)) * alpha) >> FRAC);
          node_q16 = neg ? node_q16 - longint'(prod) : node_q16 + longint'(prod);
        end
      end
      prev_time = it.time_us;
      total = node_q16;
      if (amp != '0) begin
        lcg_next = 64'(lcg_state) * 64'(LCG_MUL) + 64'(LCG_ADD);
        lcg_state = lcg_next[SEED_WIDTH-1:0];
        u = 64'(lcg_state >> NOISE_DROP_BITS);
        neg = u < 64'(NOISE_CENTRE);
        mag = (neg ? 64'(NOISE_CENTRE) - u : u - 64'(NOISE_CENTRE)) * 64'(amp);
        if (FRAC >= NOISE_HALF_BITS) mag = mag << (FRAC - NOISE_HALF_BITS);
        else mag = mag >> (NOISE_HALF_BITS - FRAC);
        total = neg ? total - longint'(mag) : total + longint'(mag);
      end
      rounded = (total + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (rounded > (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1) begin
        rounded = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
        clamped++;
      end else if (rounded < -(64'sd1 <<< (SAMPLE_WIDTH - 1))) begin
        rounded = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
        clamped++;
      end
      res.node_sample = rounded[SAMPLE_WIDTH-1:0];
      res.restarted = 1'b0;
      expected_samples.push_back(res);
    endfunction

    function void check_sample(out_item_t got);
      out_item_t want;
      if (expected_samples.size() == 0) begin
        $error("node_sample: result with no item pending, expected none, actual %0d",
          $signed(got.node_sample));
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (got.node_sample !== want.node_sample) begin
        $error("node_sample: expected %0d, actual %0d",
          $signed(want.node_sample), $signed(got.node_sample));
        errors++;
      end
      if (got.restarted !== want.restarted) begin
        $error("restarted: expected %0b, actual %0b", want.restarted, got.restarted);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  rc_node_checker sb;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  logic [TIME_WIDTH-1:0] cur_time = '0;
  logic signed [SAMPLE_WIDTH-1:0] last_target = '0;
  int n_settings = 0;
  int quiet_cycles = 0;

  rc_lowpass_noise_emulator i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_sample(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // leaves valid high after acceptance so back-to-back items can follow without valid dropping
  task automatic send_item(input logic signed [SAMPLE_WIDTH-1:0] tgt,
                           input logic [TIME_WIDTH-1:0] t);
    int gap;
    in_item_t it;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    it.target_sample = tgt;
    it.time_us = t;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cur_time = t;
    last_target = tgt;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_WIDTH-1:0] tau_v,
                             input logic [CFG_DATA_WIDTH-1:0] amp_v,
                             input logic [CFG_DATA_WIDTH-1:0] seed_v);
    drain();
    write_reg(REG_TAU, tau_v);
    write_reg(REG_AMP, amp_v);
    write_reg(REG_SEED, seed_v);
    // index past the register list must leave everything alone
    write_reg(REG_UNUSED, $urandom);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst) break;
    end
    forever begin : receiver
      int wait_cycles;
      wait_cycles = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_WIDTH-1:0] tau_v;
    logic [CFG_DATA_WIDTH-1:0] amp_v;
    logic [CFG_DATA_WIDTH-1:0] seed_v;
    logic [TIME_WIDTH-1:0] dt;
    logic [TIME_WIDTH-1:0] t;
    logic signed [SAMPLE_WIDTH-1:0] tgt;
    int r;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    n_settings = 1;

    // reset settings: zero tau, no noise
    send_item(16'sh8000, 64'd0);
    send_item(16'sh7FFF, 64'd0);
    send_item(16'sd0, 64'd5);

    reconfigure(32'd1000, 32'd0, 32'd1);
    send_item(16'sh7FFF, 64'd105);
    send_item(16'sh7FFF, 64'd105);
    send_item(-16'sd1234, 64'd900);
    send_item(16'sh8000, 64'd2000);
    send_item(16'sh7FFF, 64'd1999);
    send_item(16'sd100, 64'd2000);

    // upper data bits beyond amplitude and seed widths are set and must be dropped
    reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(16'sd0, 64'hFFFF_FFFF_FFFF_FFF0);
    send_item(16'sh7FFF, 64'hFFFF_FFFF_FFFF_FFF1);
    send_item(16'sh8000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(16'sh7FFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(16'sh7FFF, 64'd0);

    reconfigure(32'd0, 32'd1, 32'd0);
    send_item(16'sh8000, 64'd1);
    send_item(16'sh7FFF, 64'd2);

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: tau_v = 32'd0;
        1: tau_v = 32'd1;
        2: tau_v = 32'hFFFF_FFFF;
        3: tau_v = $urandom_range(2, 1000);
        4: tau_v = $urandom_range(1000, 1000000);
        default: tau_v = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: amp_v = 32'd0;
        1: amp_v = 32'd1;
        2: amp_v = 32'h7FFF;
        3: amp_v = $urandom_range(2, 64);
        default: amp_v = $urandom_range(1, 32767);
      endcase
      amp_v = amp_v | ($urandom & 32'hFFFF_8000);
      case ($urandom_range(0, 3))
        0: seed_v = 32'd0;
        1: seed_v = 32'h7FFF_FFFF;
        default: seed_v = $urandom;
      endcase
      reconfigure(tau_v, amp_v, seed_v);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          // short elapsed times, half of them inside tau when tau is above one, so the node really filters
          if (tau_v > 32'd1 && $urandom_range(0, 1) == 1) dt = 64'($urandom_range(1, tau_v - 1));
          else dt = 64'($urandom_range(1, 64));
          t = cur_time + dt;
        end else if (r < 65) begin
          t = cur_time;
        end else if (r < 85) begin
          t = cur_time + 64'(tau_v) + 64'($urandom_range(0, 100));
        end else if (r < 92) begin
          t = cur_time + {$urandom, $urandom};
        end else if ($urandom_range(0, 1) == 1) begin
          t = cur_time - 64'($urandom_range(1, 1000));
        end else begin
          t = {$urandom, $urandom};
        end
        case ($urandom_range(0, 9))
          0: tgt = 16'sh7FFF;
          1: tgt = 16'sh8000;
          2: tgt = last_target ^ 16'($urandom_range(0, 15));
          default: tgt = 16'($urandom);
        endcase
        send_item(tgt, t);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("node_sample: %0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("run covered %0d items (%0d restarts, %0d clamped outputs) under %0d settings",
      sb.seen, sb.restarts, sb.clamped, n_settings);
    $display("settings ranged over zero and full-scale tau, amplitude and seed values");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
